FILE: design/slcd_pkg.sv
package slcd_pkg;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_LEN  = 3'd1,
        PH_SRC  = 3'd2,
        PH_RCV  = 3'd3,
        PH_CMD  = 3'd4,
        PH_DATA = 3'd5,
        PH_CHK  = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_SUM   = 2'd1,
        ST_TOO_LONG  = 2'd2,
        ST_TOO_SHORT = 2'd3
    } status_t;

    typedef enum logic {
        CFG_SYNC_BYTE = 1'b0,
        CFG_MAX_FRAME = 1'b1
    } cfg_index_t;

    localparam logic [7:0] SYNC_RESET      = 8'h3B;
    localparam logic [8:0] MAX_FRAME_RESET = 9'd258;
    localparam logic [7:0] MIN_LENGTH      = 8'd3;

endpackage

FILE: design/sync_length_checksum_deframer.sv
// channel  direction  handshake          payload
// s        in         s_tvalid/s_tready  s_tdata: rx_byte
// m        out        m_tvalid/m_tready  m_tdata: frame_byte, byte_position; m_tlast; m_tuser
// cfg      in         cfg_we             cfg_index, cfg_data
//
// one word per cycle while the output is not stalled: each received byte is decoded
// in the cycle it is taken; a byte that yields a word lands in the output register.
// a new byte is taken whenever the output register is empty or is being read
// in the same cycle; a stalled output holds its word and stops the input.
// reset (rst_n low, asynchronous) returns the deframer to sync hunting with
// sync byte 0x3b and a 258 byte frame limit.
module sync_length_checksum_deframer
    import slcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] frame_byte, [16:8] byte_position, [23:17] zero
    output logic        m_tlast,   // last
    output logic [1:0]  m_tuser,   // [1:0] status

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);

    logic [7:0] sync_byte_reg;
    logic [8:0] max_frame_reg;

    phase_t     phase_reg, phase_next;
    logic [7:0] length_reg, length_next;
    logic [8:0] pos_reg, pos_next;
    logic [7:0] sum_reg, sum_next;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic [8:0] out_pos_reg;
    logic       out_last_reg;
    status_t    out_status_reg;

    logic       emit;
    logic [8:0] emit_pos;
    logic       emit_last;
    status_t    emit_status;

    logic       accept;
    logic [7:0] b;
    logic [8:0] pos_inc;
    logic [7:0] sum_add;
    logic [7:0] want;
    logic       too_short;
    logic       too_long;
    logic       last_data;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;

    assign pos_inc   = pos_reg + 9'd1;
    assign sum_add   = sum_reg + b;
    assign want      = 8'd0 - sum_reg;
    assign too_short = length_reg < MIN_LENGTH;
    assign too_long  = ({2'b00, length_reg} + 10'd3) > {1'b0, max_frame_reg};
    // last data byte sits at index length + 1
    assign last_data = pos_reg >= ({1'b0, length_reg} + 9'd1);

    // next phase
    always_comb
    begin
        unique case (phase_reg)
            PH_LEN:  phase_next = PH_SRC;
            PH_SRC:  phase_next = PH_RCV;
            PH_RCV:  phase_next = PH_CMD;
            PH_CMD:
            begin
                if (too_short || too_long)
                    phase_next = PH_HUNT;
                else if (length_reg == MIN_LENGTH)
                    phase_next = PH_CHK;
                else
                    phase_next = PH_DATA;
            end
            PH_DATA: phase_next = last_data ? PH_CHK : PH_DATA;
            PH_CHK:  phase_next = PH_HUNT;
            default: phase_next = (b == sync_byte_reg) ? PH_LEN : PH_HUNT;
        endcase
    end

    // result word and datapath updates
    always_comb
    begin
        emit        = 1'b1;
        emit_pos    = pos_reg;
        emit_last   = 1'b0;
        emit_status = ST_OK;
        length_next = length_reg;
        pos_next    = pos_inc;
        sum_next    = sum_add;
        unique case (phase_reg)
            PH_LEN:
            begin
                length_next = b;
                sum_next    = b;
            end
            PH_SRC, PH_RCV, PH_DATA:
            begin
            end
            PH_CMD:
            begin
                if (too_short)
                begin
                    emit_last   = 1'b1;
                    emit_status = ST_TOO_SHORT;
                    pos_next    = 9'd0;
                end
                else if (too_long)
                begin
                    emit_last   = 1'b1;
                    emit_status = ST_TOO_LONG;
                    pos_next    = 9'd0;
                end
            end
            PH_CHK:
            begin
                emit_last   = 1'b1;
                emit_status = (b == want) ? ST_OK : ST_BAD_SUM;
                pos_next    = 9'd0;
                sum_next    = sum_reg;
            end
            default:
            begin
                // hunting, also for the unused phase code
                emit     = (b == sync_byte_reg);
                emit_pos = 9'd0;
                pos_next = emit ? 9'd1 : pos_reg;
                sum_next = emit ? 8'd0 : sum_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_byte_reg <= SYNC_RESET;
            max_frame_reg <= MAX_FRAME_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SYNC_BYTE: sync_byte_reg <= cfg_data[7:0];
                CFG_MAX_FRAME: max_frame_reg <= cfg_data;
                default:       sync_byte_reg <= sync_byte_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            length_reg <= 8'd0;
            pos_reg    <= 9'd0;
            sum_reg    <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= emit;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_byte_reg   <= b;
            out_pos_reg    <= emit_pos;
            out_last_reg   <= emit_last;
            out_status_reg <= emit_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_pos_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

endmodule
